>>> src/frm_pkg.sv
// frm_pkg: shared constants, types and state codes of the frame rate meter
// no dependencies; used by every other file of the block
package frm_pkg;

	localparam int WINDOW = 200;

	localparam int TICK_W   = 32;
	localparam int STAMP_W  = 64;
	localparam int PERIOD_W = 16;
	localparam int FRAC_W   = 16;
	localparam int FILL_W   = $clog2(WINDOW + 1);
	localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W    = FILL_W + TICK_W;
	localparam int NUM_W    = SUM_W + FRAC_W;
	localparam int STEP_W   = $clog2(NUM_W + 1);
	localparam int CNT_W    = PERIOD_W + 1;
	localparam int CFG_W    = TICK_W;

	localparam logic [TICK_W-1:0]   TICK_RATE_RESET = TICK_W'(1000000000);
	localparam logic [PERIOD_W-1:0] PERIOD_RESET    = PERIOD_W'(60);

	localparam logic REG_TICK_RATE     = 1'b0;
	localparam logic REG_UPDATE_PERIOD = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              rd;
		logic              upd;
		logic [TICK_W-1:0] ticks;
	} win_ctl_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic [SUM_W-1:0]  total;
	} win_stat_t;

endpackage

>>> src/frm_stamp_if.sv
// frm_stamp_if: valid/ready channel carrying one frame-end timestamp
// depends on frm_pkg for the field width
interface frm_stamp_if;
	logic                         valid;
	logic                         ready;
	logic [frm_pkg::STAMP_W-1:0]  timestamp;

	modport source (output valid, output timestamp, input ready);
	modport sink   (input valid, input timestamp, output ready);
endinterface

>>> src/frm_result_if.sv
// frm_result_if: valid/ready channel carrying one frame rate result
// depends on frm_pkg for the field widths
interface frm_result_if;
	logic                        valid;
	logic                        ready;
	logic [frm_pkg::TICK_W-1:0]  frame_ticks;
	logic [frm_pkg::TICK_W-1:0]  fps_q16;
	logic                        fps_saturated;
	logic                        update_pulse;

	modport source (output valid, output frame_ticks, output fps_q16,
		output fps_saturated, output update_pulse, input ready);
	modport sink   (input valid, input frame_ticks, input fps_q16,
		input fps_saturated, input update_pulse, output ready);
endinterface

>>> src/frm_window.sv
// frm_window: frame time window store with running total, fill count and slot
// depends on frm_pkg; driven by the sequencer in frame_rate_meter_unit
module frm_window (
	input  logic               clk,
	input  logic               arst_n,
	input  frm_pkg::win_ctl_t  ctl,
	output frm_pkg::win_stat_t stat
);

	logic [frm_pkg::TICK_W-1:0] mem [frm_pkg::WINDOW];
	logic [frm_pkg::TICK_W-1:0] rd_q;
	logic [frm_pkg::SLOT_W-1:0] slot_q;
	logic [frm_pkg::FILL_W-1:0] fill_q;
	logic [frm_pkg::SUM_W-1:0]  total_q;
	logic [frm_pkg::TICK_W-1:0] old_ticks;
	logic                       full;

	// a read-back entry is only used once the window has wrapped
	assign full      = (fill_q == frm_pkg::FILL_W'(frm_pkg::WINDOW));
	assign old_ticks = full ? rd_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_q <= mem[slot_q];
		end
		if (ctl.upd) begin
			mem[slot_q] <= ctl.ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			fill_q  <= '0;
			total_q <= '0;
		end else if (ctl.upd) begin
			total_q <= total_q - frm_pkg::SUM_W'(old_ticks) + frm_pkg::SUM_W'(ctl.ticks);
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
			if (slot_q == frm_pkg::SLOT_W'(frm_pkg::WINDOW - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	assign stat.fill  = fill_q;
	assign stat.total = total_q;

endmodule

>>> src/frm_div.sv
// frm_div: restoring divider, one quotient bit per cycle
// depends on frm_pkg for operand widths
module frm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [frm_pkg::NUM_W-1:0]  num,
	input  logic [frm_pkg::SUM_W-1:0]  den,
	output logic                       busy,
	output logic                       done,
	output logic [frm_pkg::NUM_W-1:0]  quot
);

	logic [frm_pkg::NUM_W-1:0]  work_q;
	logic [frm_pkg::SUM_W-1:0]  rem_q;
	logic [frm_pkg::SUM_W-1:0]  den_q;
	logic [frm_pkg::STEP_W-1:0] step_q;
	logic                       busy_q;
	logic                       done_q;
	logic [frm_pkg::SUM_W:0]    rem_sh;
	logic [frm_pkg::SUM_W:0]    rem_sub;
	logic                       fits;

	// work_q shifts the dividend out at the top and quotient bits in at the bottom
	assign rem_sh  = {rem_q, work_q[frm_pkg::NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign fits    = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			work_q <= {work_q[frm_pkg::NUM_W-2:0], fits};
			rem_q  <= fits ? rem_sub[frm_pkg::SUM_W-1:0] : rem_sh[frm_pkg::SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == frm_pkg::STEP_W'(frm_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = work_q;

endmodule

>>> src/frame_rate_meter_unit.sv
// frame_rate_meter_unit: top level, sequencer, timestamp delta and output register
// depends on frm_pkg, frm_stamp_if, frm_result_if, frm_window and frm_div
//
// Usage: each request on the stamp channel carries the free-running counter
// value at the end of a frame. For every request one result comes out on the
// result channel: the ticks since the previous stamp (zero on the first one
// after reset, saturated to 32 bits), the windowed average frame rate
// count*tick_rate/total in unsigned Q16.16, a saturation flag and the periodic
// update pulse. tick_rate and update_period are written on the cfg port.
// Timing: stamp.ready is high only while the sequencer is idle. An accepted
// request runs through the read, update, multiply, divide and done states; the
// divide state waits on the 56-step serial divider. The next request can be
// taken the cycle after the result is loaded into the output register.
// The output register holds a finished result while the receiver stalls; the
// next request is still taken and worked on, and it waits in its last state
// until the output register is free.
// Reset clears the window (fill count to zero), the running total, the
// stamp history and the pulse counter, and loads the register reset values.
module frame_rate_meter_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	frm_stamp_if.sink                   stamp,
	frm_result_if.source                result,
	input  logic                        cfg_wr_en,
	input  logic                        cfg_index,
	input  logic [frm_pkg::CFG_W-1:0]   cfg_data
);

	frm_pkg::state_t state_q, state_d;

	logic [frm_pkg::TICK_W-1:0]   tick_rate_q;
	logic [frm_pkg::PERIOD_W-1:0] period_q;
	logic [frm_pkg::STAMP_W-1:0]  last_stamp_q;
	logic                         primed_q;
	logic [frm_pkg::TICK_W-1:0]   ticks_q;
	logic [frm_pkg::CNT_W-1:0]    items_q;
	logic                         pulse_q;
	logic [frm_pkg::CNT_W-1:0]    items_inc;

	logic                         res_valid_q;
	logic [frm_pkg::TICK_W-1:0]   res_ticks_q;
	logic [frm_pkg::TICK_W-1:0]   res_fps_q;
	logic                         res_sat_q;
	logic                         res_pulse_q;

	logic [frm_pkg::STAMP_W-1:0]  diff;
	logic [frm_pkg::TICK_W-1:0]   ticks_sat;
	logic                         accept;
	logic                         out_free;
	logic                         res_load;
	logic                         div_start;
	logic                         div_busy;
	logic                         div_done;
	logic [frm_pkg::NUM_W-1:0]    quot;
	logic [frm_pkg::SUM_W-1:0]    prod;
	logic                         q_over;

	frm_pkg::win_ctl_t  win_ctl;
	frm_pkg::win_stat_t win_stat;

	assign accept   = stamp.valid && stamp.ready;
	assign out_free = !res_valid_q || result.ready;

	// wrapping delta, saturated to 32 bits
	assign diff      = stamp.timestamp - last_stamp_q;
	assign ticks_sat = (diff[frm_pkg::STAMP_W-1:frm_pkg::TICK_W] != '0) ? '1
		: diff[frm_pkg::TICK_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			frm_pkg::ST_IDLE: begin
				if (stamp.valid) begin
					state_d = frm_pkg::ST_READ;
				end
			end
			frm_pkg::ST_READ:   state_d = frm_pkg::ST_UPDATE;
			frm_pkg::ST_UPDATE: state_d = frm_pkg::ST_MUL;
			frm_pkg::ST_MUL:    state_d = frm_pkg::ST_DIV;
			frm_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = frm_pkg::ST_DONE;
				end
			end
			frm_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = frm_pkg::ST_IDLE;
				end
			end
			default: state_d = frm_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		stamp.ready   = 1'b0;
		win_ctl.rd    = 1'b0;
		win_ctl.upd   = 1'b0;
		win_ctl.ticks = ticks_q;
		div_start     = 1'b0;
		res_load      = 1'b0;
		case (state_q)
			frm_pkg::ST_IDLE:   stamp.ready = 1'b1;
			frm_pkg::ST_READ:   win_ctl.rd  = 1'b1;
			frm_pkg::ST_UPDATE: win_ctl.upd = 1'b1;
			frm_pkg::ST_MUL:    div_start   = 1'b1;
			frm_pkg::ST_DONE:   res_load    = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= frm_pkg::TICK_RATE_RESET;
			period_q    <= frm_pkg::PERIOD_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				frm_pkg::REG_TICK_RATE:     tick_rate_q <= cfg_data;
				frm_pkg::REG_UPDATE_PERIOD: period_q    <= cfg_data[frm_pkg::PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stamp_q <= '0;
			primed_q     <= 1'b0;
		end else if (accept) begin
			last_stamp_q <= stamp.timestamp;
			primed_q     <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ticks_q <= primed_q ? ticks_sat : '0;
		end
	end

	assign items_inc = items_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q <= '0;
			pulse_q <= 1'b0;
		end else if (win_ctl.upd) begin
			if (items_inc > {1'b0, period_q}) begin
				items_q <= '0;
				pulse_q <= 1'b1;
			end else begin
				items_q <= items_inc;
				pulse_q <= 1'b0;
			end
		end
	end

	frm_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (win_ctl),
		.stat   (win_stat)
	);

	// count*tick_rate is registered in the divider's dividend register
	assign prod = frm_pkg::SUM_W'(win_stat.fill) * frm_pkg::SUM_W'(tick_rate_q);

	// a zero total gives an all-ones quotient, which lands in the saturated case
	frm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({prod, {frm_pkg::FRAC_W{1'b0}}}),
		.den    (win_stat.total),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (quot)
	);

	assign q_over = (quot[frm_pkg::NUM_W-1:frm_pkg::TICK_W] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_ticks_q <= ticks_q;
			res_fps_q   <= q_over ? '1 : quot[frm_pkg::TICK_W-1:0];
			res_sat_q   <= q_over;
			res_pulse_q <= pulse_q;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.frame_ticks   = res_ticks_q;
	assign result.fps_q16       = res_fps_q;
	assign result.fps_saturated = res_sat_q;
	assign result.update_pulse  = res_pulse_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		win_stat.fill <= frm_pkg::FILL_W'(frm_pkg::WINDOW))
		else $error("window fill count beyond window depth");

	a_idle_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		stamp.ready |-> !div_busy)
		else $error("request accepted while divider still busy");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == frm_pkg::ST_DIV)
		else $error("divider finished outside the divide state");

	a_stamp_kept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> primed_q && last_stamp_q == $past(stamp.timestamp))
		else $error("accepted timestamp not recorded");

endmodule

>>> tb/sv/tb_frame_rate_meter_unit.sv
// tb_frame_rate_meter_unit: self-checking bench for the frame rate meter top level
// depends on frm_pkg, frm_stamp_if, frm_result_if and frame_rate_meter_unit
// directed stamp table with fixed or modelled results, then random stamp phases scored against a local model
`timescale 1ns / 1ps

module tb_frame_rate_meter_unit;
	import frm_pkg::*;

	localparam int LIMIT       = 1_000_000;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE      = 70;
	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 106;
	localparam int N_DIR       = 25;

	typedef struct packed {
		logic [TICK_W-1:0] frame_ticks;
		logic [TICK_W-1:0] fps_q16;
		logic              fps_saturated;
		logic              update_pulse;
	} fps_result_t;

	typedef enum logic [0:0] {ROW_STAMP, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic               cfg_reg;
		logic [CFG_W-1:0]   value;
		logic [STAMP_W-1:0] stamp;
		logic               typed;
		fps_result_t        want;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;

	frm_stamp_if  stamp_ch ();
	frm_result_if result_ch ();

	frame_rate_meter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.stamp     (stamp_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// local model of the meter state and its registers
	logic [STAMP_W-1:0]  prev_stamp;
	logic                have_prev;
	logic [TICK_W-1:0]   win_ticks [WINDOW];
	int                  next_slot;
	int                  fill_n;
	logic [SUM_W-1:0]    run_total;
	logic [CNT_W-1:0]    pulse_count;
	logic [TICK_W-1:0]   rate_cfg;
	logic [PERIOD_W-1:0] period_cfg;

	fps_result_t expected_fps [$];
	fps_result_t monitor_want;

	int n_errors;
	int n_sent;
	int n_checked;
	int n_sat;
	int n_pulse;
	int cycle_count;

	// sender and receiver pacing
	bit tx_gaps;
	bit rx_stalls;
	int burst_left;
	int hold_requests;
	int holds_seen;
	int hold_left;
	logic [15:0] stall_pat;
	int pat_pos;

	dir_row_t dir_table [N_DIR];

	always #5 clk = ~clk;

	function automatic fps_result_t predict_fps(input logic [STAMP_W-1:0] ts);
		fps_result_t r;
		logic [63:0] diff;
		logic [63:0] num;
		logic [63:0] quot;
		r = '0;
		if (have_prev) begin
			diff = ts - prev_stamp;
			r.frame_ticks = (diff > 64'hFFFF_FFFF) ? '1 : diff[TICK_W-1:0];
		end
		have_prev = 1'b1;
		prev_stamp = ts;
		run_total = run_total - SUM_W'(win_ticks[next_slot]) + SUM_W'(r.frame_ticks);
		win_ticks[next_slot] = r.frame_ticks;
		if (fill_n < WINDOW)
			fill_n++;
		next_slot = (next_slot + 1) % WINDOW;
		if (run_total == '0) begin
			r.fps_q16 = '1;
			r.fps_saturated = 1'b1;
		end else begin
			num = (64'(fill_n) * 64'(rate_cfg)) << FRAC_W;
			quot = num / 64'(run_total);
			if (quot > 64'hFFFF_FFFF) begin
				r.fps_q16 = '1;
				r.fps_saturated = 1'b1;
			end else begin
				r.fps_q16 = quot[TICK_W-1:0];
				r.fps_saturated = 1'b0;
			end
		end
		pulse_count++;
		if (pulse_count > CNT_W'(period_cfg)) begin
			r.update_pulse = 1'b1;
			pulse_count = '0;
		end
		return r;
	endfunction

	function automatic dir_row_t stamp_row(input logic [STAMP_W-1:0] ts);
		dir_row_t row;
		row = '0;
		row.kind = ROW_STAMP;
		row.stamp = ts;
		return row;
	endfunction

	function automatic dir_row_t fixed_row(input logic [STAMP_W-1:0] ts,
			input logic [TICK_W-1:0] ticks, input logic [TICK_W-1:0] fps,
			input logic sat, input logic pulse);
		dir_row_t row;
		row = stamp_row(ts);
		row.typed = 1'b1;
		row.want = '{ticks, fps, sat, pulse};
		return row;
	endfunction

	function automatic dir_row_t write_row(input logic idx, input logic [CFG_W-1:0] v);
		dir_row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.cfg_reg = idx;
		row.value = v;
		return row;
	endfunction

	function automatic logic [STAMP_W-1:0] next_stamp(input logic [STAMP_W-1:0] cur,
			input int style);
		logic [STAMP_W-1:0] d;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 72) begin
			case (style)
				0: d = 64'($urandom_range(0, 300));
				1: d = 64'($urandom_range(1000, 1_000_000));
				2: d = 64'($urandom_range(1_000_000, 50_000_000));
				default: d = 64'($urandom);
			endcase
			return cur + d;
		end else if (pick < 80) begin
			return cur;
		end else if (pick < 88) begin
			return cur + 64'($urandom);
		end else if (pick < 94) begin
			// beyond 32 bits of ticks
			return cur + {32'($urandom_range(1, 65535)), 32'($urandom)};
		end else if (pick < 97) begin
			return cur - 64'($urandom_range(1, 1_000_000));
		end
		return {32'($urandom), 32'($urandom)};
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH at result %0d, %s: got %0h want %0h", n_checked, what, got, want);
		n_errors++;
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_TICK_RATE)
			rate_cfg = v;
		else
			period_cfg = v[PERIOD_W-1:0];
	endtask

	// drop the request and wait for every outstanding result
	task automatic drain_results;
		@(negedge clk);
		stamp_ch.valid <= 1'b0;
		while (expected_fps.size() != 0)
			@(posedge clk);
	endtask

	task automatic push_stamp(input logic [STAMP_W-1:0] ts, input logic typed,
			input fps_result_t typed_want);
		fps_result_t pred;
		int gap;
		@(negedge clk);
		stamp_ch.valid     <= 1'b1;
		stamp_ch.timestamp <= ts;
		do
			@(posedge clk);
		while (!stamp_ch.ready);
		pred = predict_fps(ts);
		expected_fps.push_back(typed ? typed_want : pred);
		n_sent++;
		gap = 0;
		if (tx_gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 70);
			end else begin
				burst_left--;
			end
		end
		if (gap > 0) begin
			@(negedge clk);
			stamp_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// receiver: random stall pattern, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_requests != holds_seen) begin
			holds_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else if (!rx_stalls) begin
			result_ch.ready <= 1'b1;
		end else begin
			result_ch.ready <= stall_pat[pat_pos];
			pat_pos = (pat_pos + 1) % 16;
			if (pat_pos == 0)
				stall_pat = 16'($urandom) | 16'h1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_fps.size() == 0) begin
				report_mismatch("result with nothing expected", 64'(result_ch.fps_q16), '0);
			end else begin
				monitor_want = expected_fps.pop_front();
				if (result_ch.frame_ticks !== monitor_want.frame_ticks)
					report_mismatch("frame_ticks", 64'(result_ch.frame_ticks),
						64'(monitor_want.frame_ticks));
				if (result_ch.fps_q16 !== monitor_want.fps_q16)
					report_mismatch("fps_q16", 64'(result_ch.fps_q16),
						64'(monitor_want.fps_q16));
				if (result_ch.fps_saturated !== monitor_want.fps_saturated)
					report_mismatch("fps_saturated", 64'(result_ch.fps_saturated),
						64'(monitor_want.fps_saturated));
				if (result_ch.update_pulse !== monitor_want.update_pulse)
					report_mismatch("update_pulse", 64'(result_ch.update_pulse),
						64'(monitor_want.update_pulse));
				n_checked++;
				if (monitor_want.fps_saturated)
					n_sat++;
				if (monitor_want.update_pulse)
					n_pulse++;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("frame_rate_meter_unit verification failed");
		$finish;
	end

	initial begin
		logic [STAMP_W-1:0] cur;
		logic [CFG_W-1:0]   rate_v;
		logic [CFG_W-1:0]   period_v;
		int                 style;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_TICK_RATE;
		cfg_data = '0;
		stamp_ch.valid = 1'b0;
		stamp_ch.timestamp = '0;
		result_ch.ready = 1'b0;
		n_errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_sat = 0;
		n_pulse = 0;
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		burst_left = 0;
		hold_requests = 0;
		holds_seen = 0;
		hold_left = 0;
		stall_pat = 16'hB6D9;
		pat_pos = 0;

		prev_stamp = '0;
		have_prev = 1'b0;
		for (int k = 0; k < WINDOW; k++)
			win_ticks[k] = '0;
		next_slot = 0;
		fill_n = 0;
		run_total = '0;
		pulse_count = '0;
		rate_cfg = TICK_RATE_RESET;
		period_cfg = PERIOD_RESET;

		dir_table = '{
			// empty window: total zero saturates
			fixed_row(64'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0),
			fixed_row(64'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0),
			// one tick over three frames overflows the quotient
			fixed_row(64'd1, 32'd1, 32'hFFFF_FFFF, 1'b1, 1'b0),
			stamp_row(64'd1_000_001),
			write_row(REG_TICK_RATE, 32'd0),
			fixed_row(64'd2_000_001, 32'd1_000_000, 32'd0, 1'b0, 1'b0),
			write_row(REG_TICK_RATE, 32'hFFFF_FFFF),
			write_row(REG_UPDATE_PERIOD, 32'd0),
			stamp_row(64'h1_001E_8480),
			stamp_row(64'h2_001E_8480),
			// backwards and wrapping stamps
			stamp_row(64'd5),
			stamp_row(64'hFFFF_FFFF_FFFF_FFFF),
			stamp_row(64'h10),
			write_row(REG_UPDATE_PERIOD, 32'd65535),
			write_row(REG_TICK_RATE, 32'd1),
			stamp_row(64'h8000_0000_0000_0000),
			stamp_row(64'h8000_0000_0000_0001),
			stamp_row(64'h5555_5555_5555_5555),
			stamp_row(64'hAAAA_AAAA_AAAA_AAAA),
			write_row(REG_UPDATE_PERIOD, 32'd1),
			write_row(REG_TICK_RATE, 32'd1_000_000_000),
			stamp_row(64'hAAAA_AAAA_AAAA_AAAA + 64'd16_666_667),
			stamp_row(64'hAAAA_AAAA_AAAA_AAAA + 64'd33_333_334),
			stamp_row(64'hAAAA_AAAA_AAAA_AAAA + 64'd50_000_001),
			stamp_row(64'hAAAA_AAAA_AAAA_AAAA + 64'd66_666_668)
		};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (dir_table[r]) begin
			if (dir_table[r].kind == ROW_WRITE) begin
				drain_results();
				write_reg(dir_table[r].cfg_reg, dir_table[r].value);
			end else begin
				push_stamp(dir_table[r].stamp, dir_table[r].typed, dir_table[r].want);
			end
		end

		for (int p = 0; p < N_PHASES; p++) begin
			drain_results();
			case (p)
				0: begin
					rate_v = 32'd1_000_000_000;
					period_v = 32'd60;
				end
				1: begin
					rate_v = 32'hFFFF_FFFF;
					period_v = 32'd0;
				end
				2: begin
					rate_v = 32'd1;
					period_v = 32'd65535;
				end
				default: begin
					case ($urandom_range(0, 3))
						0: rate_v = $urandom_range(1, 100);
						1: rate_v = $urandom;
						2: rate_v = 32'd24_000_000;
						default: rate_v = 32'hFFFF_FFFF;
					endcase
					case ($urandom_range(0, 3))
						0: period_v = $urandom_range(0, 4);
						1: period_v = $urandom_range(5, 200);
						2: period_v = 32'(16'($urandom));
						default: period_v = 32'd65535;
					endcase
				end
			endcase
			write_reg(REG_TICK_RATE, rate_v);
			write_reg(REG_UPDATE_PERIOD, period_v);
			tx_gaps = (p != 0);
			rx_stalls = (p != 0 && p != 6);
			style = p % 4;
			cur = {32'($urandom), 32'($urandom)};
			// long receiver hold-off so the block backs up into the stamp channel
			if (p == 3)
				hold_requests++;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 5 && i == PHASE_ITEMS / 2)
					drain_results();
				cur = next_stamp(cur, style);
				push_stamp(cur, 1'b0, '0);
			end
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (expected_fps.size() != 0)
			report_mismatch("results never arrived", 64'(expected_fps.size()), '0);

		$display("checked %0d results from %0d stamps over %0d register settings",
			n_checked, n_sent, N_PHASES + 5);
		$display("saturated rate on %0d results, update pulse on %0d", n_sat, n_pulse);
		if (n_errors == 0) begin
			$display("frame_rate_meter_unit verification clean");
		end else begin
			$display("frame_rate_meter_unit verification failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/frm_pkg.sv
src/frm_stamp_if.sv
src/frm_result_if.sv
src/frm_window.sv
src/frm_div.sv
src/frame_rate_meter_unit.sv
tb/sv/tb_frame_rate_meter_unit.sv
